[hdl/erat_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erat_pkg
// Shared types and constants for the event repeat and rate throttle.
// ----------------------------------------------------------------------------
package erat_pkg;

	// FNV-1a 32-bit offset basis and prime
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	// Configuration port geometry: registers at byte addresses 0, 4, 8
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_MAX_PER_WINDOW = 2'd0;
	localparam logic [1:0] REG_REPEAT_WINDOW  = 2'd1;
	localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd2;

	localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd60000;

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_BYTE   = 2'd1,
		OP_END    = 2'd2,
		OP_SETTLE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic signed [7:0]  level;
		logic [7:0]         text_byte;
		logic [63:0]        time_ms;
	} in_item_t;

	typedef struct packed {
		logic        allowed;
		logic [31:0] suppressed_total;
		logic [31:0] message_digest;
	} out_item_t;

	// Work handed from front to back: an end (decide) or a settle transaction
	typedef struct packed {
		logic        settle;
		logic [31:0] digest;
		logic [63:0] time_ms;
	} qentry_t;

	typedef struct packed {
		logic [15:0] max_per_window;
		logic [31:0] repeat_window;
		logic [31:0] window_length;
	} cfg_t;

endpackage : erat_pkg
`default_nettype wire

[hdl/event_repeat_and_rate_throttle_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// event_repeat_and_rate_throttle_top
// Log message repeat suppressor and fixed-window rate limiter.
// ----------------------------------------------------------------------------
// Feed each message as a begin transaction (level), one byte transaction per
// text byte and an end transaction (timestamp); the block answers every end
// with one result: allowed, the running suppressed count and the FNV-1a digest
// of the message. Settle transactions move the repeat reference time and give
// no result. The block takes one input transaction per clock while the queue
// is not full: the digest front does one constant multiply per byte, and the
// decision back handles one end or settle per clock, taking an end only while
// the result register is free. An accepted end waits in the queue, and the
// back registers its result when it pops that end. The short queue between
// front and back keeps input flowing while a result waits for the consumer;
// in_stall rises only when it is full. The user writes configuration registers
// (max_per_window at 0x0, repeat_window at 0x4, window_length at 0x8)
// over the APB-style port while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module event_repeat_and_rate_throttle_top import erat_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_data,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	cfg_t    cfg;
	logic    q_full;
	logic    q_empty;
	logic    q_push;
	logic    q_pop;
	qentry_t q_push_entry;
	qentry_t q_head;

	// Hold the three configuration registers
	erat_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Accept transactions, advance the digest, forward end and settle work
	erat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_stall (in_stall),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_push_entry)
	);

	// Decouple the digest front from the decision back
	erat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Decide, update throttle state, register the result
	erat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule : event_repeat_and_rate_throttle_top
`default_nettype wire

[hdl/erat_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erat_regs
// APB-style configuration registers of the throttle.
// ----------------------------------------------------------------------------
module erat_regs import erat_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_per_window <= '0;
			cfg_q.repeat_window  <= '0;
			cfg_q.window_length  <= WINDOW_LENGTH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_PER_WINDOW: cfg_q.max_per_window <= pwdata[15:0];
				REG_REPEAT_WINDOW:  cfg_q.repeat_window  <= pwdata;
				REG_WINDOW_LENGTH:  cfg_q.window_length  <= pwdata;
				default: ; // unmapped: drop the write
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_PER_WINDOW: prdata = {16'd0, cfg_q.max_per_window};
			REG_REPEAT_WINDOW:  prdata = cfg_q.repeat_window;
			REG_WINDOW_LENGTH:  prdata = cfg_q.window_length;
			default:            prdata = '0;
		endcase
	end

endmodule : erat_regs
`default_nettype wire

[hdl/erat_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erat_front
// Input side: accepts transactions, runs the FNV-1a digest and forwards
// end and settle transactions to the decision queue.
// ----------------------------------------------------------------------------
module erat_front import erat_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_item_t in_data,
	output logic          in_stall,
	input  wire logic     q_full,
	output logic          q_push,
	output qentry_t       q_entry
);

	logic [31:0] digest_q;
	logic [31:0] digest_d;
	logic [31:0] mix_in;
	logic [31:0] mix_out;
	logic [31:0] level_ext;
	logic        accept;

	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign level_ext = {{24{in_data.level[7]}}, in_data.level};

	// One shared mixing multiplier: begin seeds from the basis, bytes chain
	assign mix_in  = (in_data.operation == OP_BEGIN) ? (FNV_BASIS ^ level_ext)
	                                                 : (digest_q ^ {24'd0, in_data.text_byte});
	assign mix_out = 32'(mix_in * FNV_PRIME);

	always_comb begin
		digest_d = digest_q;
		q_push   = 1'b0;
		case (in_data.operation)
			OP_BEGIN:  digest_d = mix_out;
			OP_BYTE:   digest_d = mix_out;
			OP_END: begin
				digest_d = FNV_BASIS;
				q_push   = accept;
			end
			OP_SETTLE: q_push   = accept;
			default:   digest_d = digest_q;
		endcase
	end

	assign q_entry.settle  = (in_data.operation == OP_SETTLE);
	assign q_entry.digest  = digest_q;
	assign q_entry.time_ms = in_data.time_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_q <= FNV_BASIS;
		end else if (accept) begin
			digest_q <= digest_d;
		end
	end

endmodule : erat_front
`default_nettype wire

[hdl/erat_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erat_queue
// Short FIFO between the digest front and the decision back.
// ----------------------------------------------------------------------------
module erat_queue import erat_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire qentry_t push_entry,
	input  wire logic    pop,
	output qentry_t      head,
	output logic         empty,
	output logic         full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	qentry_t          entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule : erat_queue
`default_nettype wire

[hdl/erat_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erat_back
// Decision side: applies the repeat and window count rules and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module erat_back import erat_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire qentry_t head,
	input  wire logic    q_empty,
	output logic         q_pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output out_item_t    out_data
);

	logic [31:0] last_digest_q;
	logic [63:0] last_time_q;
	logic        have_last_q;
	logic [63:0] win_start_q;
	logic [15:0] sent_q;
	logic [31:0] supp_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic        out_free;
	logic        decide;
	logic [63:0] since_last;
	logic [63:0] since_win;
	logic        repeat_hit;
	logic        count_on;
	logic        new_window;
	logic [15:0] sent_eff;
	logic        allowed;
	logic [31:0] supp_next;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = !q_empty && (head.settle || out_free);
	assign decide   = q_pop && !head.settle;

	assign since_last = head.time_ms - last_time_q;
	assign since_win  = head.time_ms - win_start_q;

	assign repeat_hit = (cfg.repeat_window != '0) && have_last_q &&
	                    (head.digest == last_digest_q) &&
	                    (since_last < {32'd0, cfg.repeat_window});
	assign count_on   = (cfg.max_per_window != '0);
	assign new_window = (since_win >= {32'd0, cfg.window_length});
	assign sent_eff   = new_window ? '0 : sent_q;
	assign allowed    = !repeat_hit && !(count_on && (sent_eff >= cfg.max_per_window));
	assign supp_next  = allowed ? supp_q : supp_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_digest_q <= '0;
			last_time_q   <= '0;
			have_last_q   <= 1'b0;
			win_start_q   <= '0;
			sent_q        <= '0;
			supp_q        <= '0;
		end else if (decide) begin
			supp_q <= supp_next;
			if (!repeat_hit && count_on) begin
				if (new_window) begin
					win_start_q <= head.time_ms;
				end
				sent_q <= allowed ? sent_eff + 1'b1 : sent_eff;
			end
			if (allowed) begin
				last_digest_q <= head.digest;
				last_time_q   <= head.time_ms;
				have_last_q   <= 1'b1;
			end
		end else if (q_pop && have_last_q) begin
			// settle: advance the repeat reference time
			last_time_q <= head.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			out_data_q.allowed          <= allowed;
			out_data_q.suppressed_total <= supp_next;
			out_data_q.message_digest   <= head.digest;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule : erat_back
`default_nettype wire
